FILE: rtl/core/wset_pkg.sv
// ----------------------------------------------------------------------------
// wset_pkg
// Shared types and constants for the weight sorted edge table: request and
// status codes, controller states and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package wset_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int VERT_W   = 10;
  localparam int WEIGHT_W = 32;
  localparam int EDGE_W   = 2 * VERT_W + WEIGHT_W;
  localparam int POS_W    = 6;
  localparam int CNT_W    = 7;
  localparam int S_DATA_W = 56;
  localparam int M_DATA_W = 48;

  typedef enum logic [1:0] {
    OP_FRONT  = 2'd0,
    OP_SORTED = 2'd1,
    OP_FIND   = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RD_IDX    = 2'd0,
    RD_IDX_DN = 2'd1,
    RD_IDX_UP = 2'd2
  } rd_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHUP_RD,
    S_SHUP_WR,
    S_SHDN_RD,
    S_SHDN_WR,
    S_RESP
  } state_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] w;
    logic [VERT_W-1:0]          b;
    logic [VERT_W-1:0]          a;
  } edge_t;

  typedef struct packed {
    logic    load_req;
    logic    idx_clear;
    logic    idx_inc;
    logic    idx_dec;
    logic    idx_from_count;
    logic    pos_zero;
    logic    pos_from_idx;
    logic    rd;
    rd_sel_t rd_sel;
    logic    wr_shift;
    logic    wr_new;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_set;
    status_t res_code;
    logic    res_keep_w;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic scan_end;
    logic hit;
    logic up_done;
    logic dn_done;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/core/wset_ctrl.sv
// ----------------------------------------------------------------------------
// wset_ctrl
// Sequencer for the edge table: dispatches a request, steps the scan and the
// shift loops one entry at a time and hands the result to the output word.
// ----------------------------------------------------------------------------
module wset_ctrl
  import wset_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  input  stat_t stat,
  output logic  s_tready,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (stat.op == OP_FRONT || stat.op == OP_SORTED) begin
          if (stat.full) state_next = S_RESP;
          else if (stat.op == OP_FRONT) state_next = S_SHUP_RD;
          else state_next = S_SCAN_RD;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (!stat.scan_end) state_next = S_SCAN_CHK;
        else if (stat.op == OP_SORTED) state_next = S_SHUP_RD;
        else state_next = S_RESP;
      end
      S_SCAN_CHK: begin
        if (!stat.hit) state_next = S_SCAN_RD;
        else if (stat.op == OP_REMOVE) state_next = S_SHDN_RD;
        else if (stat.op == OP_FIND) state_next = S_RESP;
        else state_next = S_SHUP_RD;
      end
      S_SHUP_RD: begin
        if (stat.up_done) state_next = S_RESP;
        else state_next = S_SHUP_WR;
      end
      S_SHUP_WR: state_next = S_SHUP_RD;
      S_SHDN_RD: begin
        if (stat.dn_done) state_next = S_RESP;
        else state_next = S_SHDN_WR;
      end
      S_SHDN_WR: state_next = S_SHDN_RD;
      S_RESP: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.rd_sel   = RD_IDX;
    cmd.res_code = ST_DONE;
    s_tready = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready     = 1'b1;
        cmd.load_req = s_tvalid;
      end
      S_DISPATCH: begin
        if ((stat.op == OP_FRONT || stat.op == OP_SORTED) && stat.full) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_FULL;
        end else if (stat.op == OP_FRONT) begin
          cmd.pos_zero       = 1'b1;
          cmd.idx_from_count = 1'b1;
        end else begin
          cmd.idx_clear = 1'b1;
        end
      end
      S_SCAN_RD: begin
        if (!stat.scan_end) begin
          cmd.rd = 1'b1;
        end else if (stat.op == OP_SORTED) begin
          // ran past every stored edge: append at the tail
          cmd.pos_from_idx   = 1'b1;
          cmd.idx_from_count = 1'b1;
        end else begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_NOT_FOUND;
        end
      end
      S_SCAN_CHK: begin
        if (!stat.hit) begin
          cmd.idx_inc = 1'b1;
        end else if (stat.op == OP_SORTED) begin
          cmd.pos_from_idx   = 1'b1;
          cmd.idx_from_count = 1'b1;
        end else begin
          cmd.pos_from_idx = 1'b1;
          cmd.res_set      = 1'b1;
          cmd.res_keep_w   = 1'b1;
        end
      end
      S_SHUP_RD: begin
        if (stat.up_done) begin
          cmd.wr_new  = 1'b1;
          cmd.cnt_inc = 1'b1;
          cmd.res_set = 1'b1;
        end else begin
          cmd.rd     = 1'b1;
          cmd.rd_sel = RD_IDX_DN;
        end
      end
      S_SHUP_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_dec  = 1'b1;
      end
      S_SHDN_RD: begin
        if (stat.dn_done) begin
          cmd.cnt_dec = 1'b1;
        end else begin
          cmd.rd     = 1'b1;
          cmd.rd_sel = RD_IDX_UP;
        end
      end
      S_SHDN_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
      end
      S_RESP: begin
        cmd.out_load = stat.out_free;
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_SHUP_WR) |-> ($past(state) == S_SHUP_RD))
    else $error("shift-up write without a preceding read");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_SHDN_WR) |-> ($past(state) == S_SHDN_RD))
    else $error("shift-down write without a preceding read");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_CHK) |-> ($past(state) == S_SCAN_RD))
    else $error("scan check without a read");

endmodule

FILE: rtl/core/wset_dpath.sv
// ----------------------------------------------------------------------------
// wset_dpath
// Datapath of the edge table: request registers, the edge memory with one
// write and one registered read port, scan index, count, and result word.
// ----------------------------------------------------------------------------
module wset_dpath
  import wset_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
)(
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  input  logic [1:0]          s_tuser,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic                m_tready,
  output stat_t               stat,
  output logic                m_tvalid,
  output logic [1:0]          m_tuser,
  output logic [M_DATA_W-1:0] m_tdata
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  edge_t mem [CAPACITY];

  op_t     req_op;
  edge_t   req;
  edge_t   rd_edge;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx_rd;
  logic [AW-1:0] pos;
  status_t res_code;
  logic signed [WEIGHT_W-1:0] res_w;

  logic       out_valid;
  status_t    out_status;
  logic signed [WEIGHT_W-1:0] out_w;
  logic [POS_W-1:0] out_pos;
  logic [CNT_W-1:0] out_count;
  logic       out_empty;

  logic [AW-1:0] waddr;
  edge_t         wdata;
  logic          wen;
  logic          less;
  logic          match;
  logic [31:0]   pos_ext;
  logic [31:0]   count_ext;

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      RD_IDX_DN: idx_rd = idx - CW'(1);
      RD_IDX_UP: idx_rd = idx + CW'(1);
      default:   idx_rd = idx;
    endcase
  end

  assign wen   = cmd.wr_shift | cmd.wr_new;
  assign waddr = cmd.wr_new ? pos : idx[AW-1:0];
  assign wdata = cmd.wr_new ? req : rd_edge;

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    if (cmd.rd) rd_edge <= mem[idx_rd[AW-1:0]];
  end

  // compare the entry just read against the request
  assign less  = $signed(rd_edge.w) < $signed(req.w);
  assign match = (rd_edge.a == req.a || rd_edge.b == req.a) &&
                 (rd_edge.a == req.b || rd_edge.b == req.b);

  assign stat.op       = req_op;
  assign stat.full     = (count == CW'(CAPACITY));
  assign stat.scan_end = (idx == count);
  assign stat.hit      = (req_op == OP_SORTED) ? !less : match;
  assign stat.up_done  = (idx == CW'(pos));
  assign stat.dn_done  = ((idx + CW'(1)) == count);
  assign stat.out_free = !out_valid || m_tready;

  always_comb begin
    count_next = count;
    if (cmd.cnt_inc) count_next = count + CW'(1);
    else if (cmd.cnt_dec) count_next = count - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  assign pos_ext   = 32'(pos);
  assign count_ext = 32'(count);

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op <= op_t'(s_tuser);
      req    <= edge_t'(s_tdata[EDGE_W-1:0]);
    end
    if (cmd.idx_clear) idx <= '0;
    else if (cmd.idx_from_count) idx <= count;
    else if (cmd.idx_inc) idx <= idx + CW'(1);
    else if (cmd.idx_dec) idx <= idx - CW'(1);
    if (cmd.pos_zero) pos <= '0;
    else if (cmd.pos_from_idx) pos <= idx[AW-1:0];
    if (cmd.res_set) begin
      res_code <= cmd.res_code;
      res_w    <= cmd.res_keep_w ? rd_edge.w : '0;
    end
    if (cmd.out_load) begin
      out_status <= res_code;
      out_w      <= res_w;
      out_pos    <= (res_code == ST_DONE) ? pos_ext[POS_W-1:0] : '0;
      out_count  <= count_ext[CNT_W-1:0];
      out_empty  <= (count == '0);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {2'b00, out_empty, out_count, out_pos, out_w};

  assert property (@(posedge clk) disable iff (rst) count <= CW'(CAPACITY))
    else $error("edge count above capacity");

  assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> (count != CW'(CAPACITY)))
    else $error("insert into a full table");

  assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_dec |-> (count != '0))
    else $error("remove from an empty table");

  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("result word lost on load");

endmodule

FILE: rtl/core/weight_sorted_edge_table.sv
// ----------------------------------------------------------------------------
// weight_sorted_edge_table
// Ordered table of graph edges (two endpoints and a signed weight) with
// front insert, weight-sorted insert, find and remove, one request at a time.
//
//  channel  dir  handshake          tuser            tdata (low bit up)
//  s_*      in   s_tvalid/s_tready  operation [1:0]  end_a, end_b, weight
//  m_*      out  m_tvalid/m_tready  status [1:0]     match_weight,
//                                                    match_position,
//                                                    entry_count, is_empty
//
// The scan and the shift each move one entry at a time, a read and then a
// check or a write, through the single read port and the single write port
// of the edge memory.
// Reset empties the table at once; stored entries are not cleared.
// A new request is taken while the previous result waits on m_tready; a
// finished request holds in its last state until the result word is free.
// ----------------------------------------------------------------------------
module weight_sorted_edge_table
  import wset_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
)(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // end_a[9:0], end_b[19:10], weight[51:20]
  input  logic [1:0]          s_tuser,   // operation[1:0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // match_weight[31:0], match_position[37:32],
                                         // entry_count[44:38], is_empty[45]
  output logic [1:0]          m_tuser    // status[1:0]
);

  cmd_t  cmd;
  stat_t stat;

  wset_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .stat     (stat),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  wset_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tready (m_tready),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
  );

endmodule
